/* design/mhpq_pkg.sv */
// Shared types, constants and handshake structs for the max-heap priority queue.
package mhpq_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int TAG_W          = 16;
    localparam int LIMIT_W        = 7;
    localparam int COUNT_OUT_W    = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_POP_LAST,
        S_POP_LOAD,
        S_POP_CMP,
        S_POP_KIDS,
        S_ROOT_RD,
        S_ROOT_OUT
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_LAST,
        RD_KIDS,
        RD_ROOT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOV,
        WR_PARENT,
        WR_CHILD
    } wr_sel_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_COUNT,
        POS_ZERO,
        POS_PARENT,
        POS_CHILD
    } pos_sel_t;

    typedef struct packed {
        logic     load_item;
        status_t  status;
        logic     cnt_inc;
        logic     cnt_dec;
        pos_sel_t pos_sel;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     load_mov_rd;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic in_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic rise;
        logic sink;
        logic out_free;
    } stat_t;

endpackage

/* design/mhpq_ctrl.sv */
// Controller state machine sequencing insert, pop and root read-back.
module mhpq_ctrl import mhpq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!stat.in_pop) begin
                        state_next = stat.full ? S_ROOT_RD : S_INS_CHK;
                    end else begin
                        state_next = stat.empty ? S_ROOT_RD : S_POP_LAST;
                    end
                end
            end
            S_INS_CHK: begin
                state_next = stat.pos_zero ? S_ROOT_RD : S_INS_CMP;
            end
            S_INS_CMP: begin
                state_next = stat.rise ? S_INS_CHK : S_ROOT_RD;
            end
            S_POP_LAST: begin
                state_next = stat.empty ? S_ROOT_RD : S_POP_LOAD;
            end
            S_POP_LOAD: begin
                state_next = S_POP_CMP;
            end
            S_POP_CMP: begin
                state_next = stat.sink ? S_POP_KIDS : S_ROOT_RD;
            end
            S_POP_KIDS: begin
                state_next = S_POP_CMP;
            end
            S_ROOT_RD: begin
                state_next = S_ROOT_OUT;
            end
            S_ROOT_OUT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.status   = ST_DONE;
        cmd.pos_sel  = POS_HOLD;
        cmd.rd_sel   = RD_NONE;
        cmd.wr_sel   = WR_NONE;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    if (!stat.in_pop) begin
                        if (stat.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.cnt_inc = 1'b1;
                            cmd.pos_sel = POS_COUNT;
                        end
                    end else begin
                        if (stat.empty) begin
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.cnt_dec = 1'b1;
                            cmd.pos_sel = POS_ZERO;
                        end
                    end
                end
            end
            S_INS_CHK: begin
                if (stat.pos_zero) begin
                    cmd.wr_sel = WR_MOV;
                end else begin
                    cmd.rd_sel = RD_PARENT;
                end
            end
            S_INS_CMP: begin
                if (stat.rise) begin
                    cmd.wr_sel  = WR_PARENT;
                    cmd.pos_sel = POS_PARENT;
                end else begin
                    cmd.wr_sel = WR_MOV;
                end
            end
            S_POP_LAST: begin
                if (!stat.empty) begin
                    cmd.rd_sel = RD_LAST;
                end
            end
            S_POP_LOAD: begin
                cmd.load_mov_rd = 1'b1;
                cmd.rd_sel      = RD_KIDS;
            end
            S_POP_CMP: begin
                if (stat.sink) begin
                    cmd.wr_sel  = WR_CHILD;
                    cmd.pos_sel = POS_CHILD;
                end else begin
                    cmd.wr_sel = WR_MOV;
                end
            end
            S_POP_KIDS: begin
                cmd.rd_sel = RD_KIDS;
            end
            S_ROOT_RD: begin
                cmd.rd_sel = RD_ROOT;
            end
            S_ROOT_OUT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* design/mhpq_dp.sv */
// Datapath: heap memory, count, limit, moving entry, hole index and result register.
module mhpq_dp import mhpq_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wen,
    input  logic [LIMIT_W-1:0]       cfg_wdata,
    input  logic                     in_op,
    input  logic signed [KEY_W-1:0]  in_key,
    input  logic [TAG_W-1:0]         in_tag,
    input  logic                     m_tready,
    output logic                     m_valid,
    output status_t                  out_status,
    output logic                     out_top_valid,
    output logic signed [KEY_W-1:0]  out_key,
    output logic [TAG_W-1:0]         out_tag,
    output logic [COUNT_OUT_W-1:0]   out_count,
    input  cmd_t                     cmd,
    output stat_t                    stat
);

    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = IW + 2;
    localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;

    entry_t mem [HEAP_DEPTH];

    logic [CW-1:0]      count_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [IW-1:0]      pos_reg;
    entry_t             mov_reg;
    status_t            status_reg;
    entry_t             rd_a_reg;
    entry_t             rd_b_reg;
    logic               m_valid_reg;

    logic [IW-1:0] parent_idx;
    logic [KW-1:0] kid_l;
    logic [KW-1:0] kid_r;
    logic          l_ok;
    logic          r_ok;
    logic          take_l;
    logic          take_r;
    logic signed [KEY_W-1:0] best_key;
    logic [IW-1:0] child_idx;
    entry_t        child_ent;
    logic [IW-1:0] rd_addr_a;
    logic          rd_en;
    logic [XW-1:0] count_x;
    entry_t        wr_data;
    logic          wr_en;

    assign parent_idx = (pos_reg - IW'(1)) >> 1;
    assign kid_l      = (KW'(pos_reg) << 1) + KW'(1);
    assign kid_r      = (KW'(pos_reg) << 1) + KW'(2);
    assign l_ok       = kid_l < KW'(count_reg);
    assign r_ok       = kid_r < KW'(count_reg);
    assign take_l     = l_ok && ($signed(rd_a_reg.key) > $signed(mov_reg.key));
    assign best_key   = take_l ? rd_a_reg.key : mov_reg.key;
    assign take_r     = r_ok && ($signed(rd_b_reg.key) > $signed(best_key));
    assign child_idx  = take_r ? kid_r[IW-1:0] : kid_l[IW-1:0];
    assign child_ent  = take_r ? rd_b_reg : rd_a_reg;
    assign count_x    = XW'(count_reg);

    always_comb begin
        stat.in_pop   = in_op;
        stat.full     = (count_x >= XW'(limit_reg)) || (count_reg == CW'(HEAP_DEPTH));
        stat.empty    = (count_reg == '0);
        stat.pos_zero = (pos_reg == '0);
        stat.rise     = $signed(mov_reg.key) > $signed(rd_a_reg.key);
        stat.sink     = take_l || take_r;
        stat.out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        rd_en     = 1'b1;
        rd_addr_a = '0;
        case (cmd.rd_sel)
            RD_PARENT: rd_addr_a = parent_idx;
            RD_LAST:   rd_addr_a = count_reg[IW-1:0];
            RD_KIDS:   rd_addr_a = kid_l[IW-1:0];
            RD_ROOT:   rd_addr_a = '0;
            default:   rd_en     = 1'b0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_data = mov_reg;
        case (cmd.wr_sel)
            WR_MOV:    wr_data = mov_reg;
            WR_PARENT: wr_data = rd_a_reg;
            WR_CHILD:  wr_data = child_ent;
            default:   wr_en   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[pos_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[kid_r[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mov_reg.key <= in_key;
            mov_reg.tag <= in_tag;
            status_reg  <= cmd.status;
        end else if (cmd.load_mov_rd) begin
            mov_reg <= rd_a_reg;
        end
        case (cmd.pos_sel)
            POS_COUNT:  pos_reg <= count_reg[IW-1:0];
            POS_ZERO:   pos_reg <= '0;
            POS_PARENT: pos_reg <= parent_idx;
            POS_CHILD:  pos_reg <= child_idx;
            default:    pos_reg <= pos_reg;
        endcase
        if (cmd.load_out) begin
            out_status    <= status_reg;
            out_top_valid <= (count_reg != '0);
            out_key       <= (count_reg != '0) ? rd_a_reg.key : '0;
            out_tag       <= (count_reg != '0) ? rd_a_reg.tag : '0;
            out_count     <= count_x[COUNT_OUT_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("entry count exceeds heap depth");

    a_refused_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item && (cmd.status != ST_DONE) |=> count_reg == $past(count_reg))
        else $error("refused operation changed the count");

    a_top_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg && (out_top_valid == (count_reg != '0)))
        else $error("reported top valid disagrees with count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while stalled");
`endif

endmodule

/* design/max_heap_priority_queue.sv */
// Top level of the binary max-heap priority queue: controller plus datapath.
//
// Usage: each input item on the s_ channel is an insert (s_tuser = 0) of the
// (key, tag) pair in s_tdata, or a pop (s_tuser = 1) of the largest key. Every
// item gives exactly one result item on the m_ channel: a status code in
// m_tuser with a top-valid flag, and the root entry and count in m_tdata.
// An insert when the count has reached min(capacity_limit, HEAP_DEPTH) is
// refused as full; a pop of an empty heap is refused as empty.
// An insert reads the parent and compares, per level, until the entry stops
// or reaches the root; a pop reads the last entry, moves it to the root and
// compares it with both children per level; a refused item does neither.
// Every item ends with a root read into the output register. An entry moves
// at most log2 of HEAP_DEPTH levels. One item is worked on at a time: a new
// one is accepted only after the last result is loaded. Each level has a read
// and a compare step as the single heap memory registers its read data first.
// Reset empties the heap and sets capacity_limit to 64; no memory clearing
// pass runs. A stalled receiver holds the result in the output register;
// the next item is still accepted and worked on, and waits for the register.
// Users write capacity_limit via cfg_wen/cfg_wdata while the block idles (not enforced).
module max_heap_priority_queue import mhpq_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // new_key[31:0], new_tag[47:32]
    input  logic [0:0]         s_tuser,   // opcode[0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // top_key[31:0], top_tag[47:32], entry_count[54:48]
    output logic [2:0]         m_tuser    // status[1:0], top_valid[2]
);

    cmd_t    cmd;
    stat_t   stat;
    status_t out_status;
    logic    out_top_valid;
    logic signed [KEY_W-1:0]  out_key;
    logic [TAG_W-1:0]         out_tag;
    logic [COUNT_OUT_W-1:0]   out_count;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_op         (s_tuser[0]),
        .in_key        (s_tdata[31:0]),
        .in_tag        (s_tdata[47:32]),
        .m_tready      (m_tready),
        .m_valid       (m_tvalid),
        .out_status    (out_status),
        .out_top_valid (out_top_valid),
        .out_key       (out_key),
        .out_tag       (out_tag),
        .out_count     (out_count),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign m_tdata = {1'b0, out_count, out_tag, out_key};
    assign m_tuser = {out_top_valid, out_status};

endmodule
